// ===== rtl/apit_pkg.sv =====
`default_nettype none

package apit_pkg;

  // Default table size and fixed field widths.
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int ID_W              = 32;
  localparam int CMD_W             = 3;
  localparam int SLOT_W            = 3;
  localparam int COUNT_OUT_W       = 4;

  // Stream payload widths; the tdata widths are padded to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = CMD_W;
  localparam int M_TDATA_W = 40;

  // Positions of the result fields in the output tdata.
  localparam int M_OK_LSB      = 0;
  localparam int M_VALUE_LSB   = 1;
  localparam int M_COUNT_LSB   = 33;
  localparam int M_CHANGED_LSB = 37;

  // IDs that may never be added.
  localparam logic [ID_W-1:0] ID_NONE     = 32'h0000_0000;
  localparam logic [ID_W-1:0] ID_ALL_ONES = 32'hFFFF_FFFF;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/paired_id_allow_table_top.sv =====
`default_nettype none
// Clear, unused commands and refused IDs go straight to the result. A read fetches the slot
// and waits for the registered read data. A check or add walks the held slots (one held slot per
// cycle), and a remove then moves each later entry down one slot.
// One request at a time; the next is taken once the result is presented.
// Reset: synchronous, active high; the count returns to zero and the block is then ready.
module paired_id_allow_table_top
  import apit_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata from bit 0: req_id[31:0], slot_index[34:32], zero padding[39:35].
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser from bit 0: cmd[2:0].
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  // Result stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata from bit 0: ok[0], slot_value[32:1], entry_count[36:33],
  // table_changed[37], zero padding[39:38].
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
  localparam int PADW = M_TDATA_W - M_CHANGED_LSB - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  state_t            state;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   req_id;
  logic [SLOT_W-1:0] slot_index;
  logic [CW-1:0]     count;
  logic [CW-1:0]     issue_idx;
  logic              pend;
  logic [AW-1:0]     pend_pos;
  logic              res_ok;
  logic [ID_W-1:0]   res_value;
  logic              res_changed;

  // Slot memory with one write and one registered read port.
  logic [ID_W-1:0] mem [TABLE_ENTRIES];
  logic [ID_W-1:0] rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ID_W-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  logic            match;
  logic            scan_hit;
  logic            scan_miss;
  logic            room;
  logic            slot_held;
  logic            out_free;
  logic [COUNT_OUT_W-1:0] count_out;

  // The shared comparator: the ID in the request against the slot just read.
  assign match     = (rd_data == req_id);
  assign scan_hit  = pend && match;
  assign scan_miss = !scan_hit && (issue_idx == count);
  assign room      = (count < CW'(TABLE_ENTRIES));
  assign slot_held = (CMPW'(slot_index) < CMPW'(count));
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign count_out = (CMPW'(count) > CMPW'(15)) ? COUNT_OUT_W'(15) : COUNT_OUT_W'(count);

  assign s_axis_tready = (state == ST_IDLE);

  // Memory port control for each sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = req_id;
    mem_re    = 1'b0;
    mem_raddr = issue_idx[AW-1:0];
    unique case (state)
      ST_SCAN: begin
        mem_re = !scan_hit && (issue_idx != count);
        mem_we = scan_miss && (cmd == CMD_ADD) && room;
      end
      ST_SHIFT: begin
        mem_re    = (issue_idx != count);
        mem_we    = pend;
        mem_waddr = pend_pos - AW'(1);
        mem_wdata = rd_data;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(slot_index);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequencer: dispatch, slot walk, shift down, read and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      pend          <= 1'b0;
      issue_idx     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The result register loads in the done state and empties once taken.
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      pend     <= mem_re;
      pend_pos <= mem_raddr;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd         <= s_axis_tuser;
            req_id      <= s_axis_tdata[ID_W-1:0];
            slot_index  <= s_axis_tdata[ID_W +: SLOT_W];
            issue_idx   <= '0;
            res_ok      <= 1'b0;
            res_value   <= '0;
            res_changed <= 1'b0;
            unique case (s_axis_tuser)
              CMD_CHECK, CMD_REMOVE: begin
                state <= ST_SCAN;
              end
              CMD_ADD: begin
                if (s_axis_tdata[ID_W-1:0] == ID_NONE ||
                    s_axis_tdata[ID_W-1:0] == ID_ALL_ONES) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              CMD_CLEAR: begin
                count       <= '0;
                res_changed <= 1'b1;
                state       <= ST_DONE;
              end
              CMD_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            if (cmd == CMD_REMOVE) begin
              res_changed <= 1'b1;
              issue_idx   <= CW'(pend_pos) + CW'(1);
              state       <= ST_SHIFT;
            end else begin
              res_ok <= 1'b1;
              state  <= ST_DONE;
            end
          end else if (scan_miss) begin
            if (cmd == CMD_CHECK) begin
              res_ok <= (count == '0);
            end else if (cmd == CMD_ADD && room) begin
              count       <= count + CW'(1);
              res_ok      <= 1'b1;
              res_changed <= 1'b1;
            end
            state <= ST_DONE;
          end else begin
            issue_idx <= issue_idx + CW'(1);
          end
        end
        ST_SHIFT: begin
          if (issue_idx != count) begin
            issue_idx <= issue_idx + CW'(1);
          end else if (!pend) begin
            count <= count - CW'(1);
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_READ_WAIT;
        end
        ST_READ_WAIT: begin
          res_value <= slot_held ? rd_data : '0;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata <= {PADW'(0), res_changed, count_out, res_value, res_ok};
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/apit_checker.sv =====
`default_nettype none

module apit_checker
  import apit_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int MAX_COUNT = (TABLE_ENTRIES > 15) ? 15 : TABLE_ENTRIES;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block is ready straight after reset.
  assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("not ready after reset");

  // The block is not ready in the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one was still in work");

  // The reported count never exceeds the table size.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[M_COUNT_LSB +: COUNT_OUT_W] <= COUNT_OUT_W'(MAX_COUNT))
    else $error("entry count beyond table size");

  // A non-zero slot value only comes from a read, which neither passes nor modifies.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[M_VALUE_LSB +: ID_W] != '0)
      |-> !m_axis_tdata[M_OK_LSB] && !m_axis_tdata[M_CHANGED_LSB])
    else $error("slot value reported with ok or changed set");

endmodule

bind paired_id_allow_table_top apit_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_apit_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import apit_pkg::*;

  localparam int ENTRIES          = TABLE_ENTRIES_DEF;
  localparam int RANDOM_REQUESTS  = 1100;
  localparam int CALM_TAIL        = 150;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 48;
  localparam int POOL_SIZE        = 12;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic                   ok;
    logic [ID_W-1:0]        value;
    logic [COUNT_OUT_W-1:0] count;
    logic                   changed;
  } verdict_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Requests waiting to be offered, and verdicts waiting to come back.
  request_t    queued_requests[$];
  verdict_t    pending_verdicts[$];
  request_t    on_bus;
  int unsigned requests_total = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  logic        tail_calm      = 1'b0;

  // Shadow copy of the allow-list.
  logic [ID_W-1:0] shadow_ids[ENTRIES];
  int unsigned     shadow_count;
  logic [ID_W-1:0] known_ids[POOL_SIZE];

  paired_id_allow_table_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Applies one request to the shadow list and returns the verdict it should produce.
  function automatic verdict_t apply_to_allow_list(input request_t r);
    verdict_t v;
    int       pos;
    bit       found;
    v     = '0;
    pos   = 0;
    found = 1'b0;
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (!found && shadow_ids[i] == r.id) begin
        found = 1'b1;
        pos   = i;
      end
    end
    case (r.cmd)
      CMD_CHECK: begin
        v.ok = (shadow_count == 0) || found;
      end
      CMD_ADD: begin
        if (r.id == ID_NONE || r.id == ID_ALL_ONES) begin
          v.ok = 1'b0;
        end else if (found) begin
          v.ok = 1'b1;
        end else if (shadow_count < ENTRIES) begin
          shadow_ids[shadow_count] = r.id;
          shadow_count++;
          v.ok      = 1'b1;
          v.changed = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          for (int j = pos; j + 1 < int'(shadow_count); j++) begin
            shadow_ids[j] = shadow_ids[j + 1];
          end
          shadow_count--;
          shadow_ids[shadow_count] = '0;
          v.changed = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int j = 0; j < ENTRIES; j++) begin
          shadow_ids[j] = '0;
        end
        shadow_count = 0;
        v.changed    = 1'b1;
      end
      CMD_READ: begin
        if (r.slot < ENTRIES) begin
          v.value = shadow_ids[r.slot];
        end
      end
      default: begin
      end
    endcase
    v.count = (shadow_count > (2 ** COUNT_OUT_W - 1)) ? '1 : COUNT_OUT_W'(shadow_count);
    return v;
  endfunction

  function automatic request_t make_request(input logic [CMD_W-1:0] cmd,
                                            input logic [ID_W-1:0] id,
                                            input logic [SLOT_W-1:0] slot);
    request_t r;
    r.cmd  = cmd;
    r.id   = id;
    r.slot = slot;
    return r;
  endfunction

  // Mostly pool IDs so that hits, duplicates and a full table are common.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (sel < 75) begin
      r.id = known_ids[$urandom_range(0, POOL_SIZE - 1)];
    end else if (sel < 85) begin
      r.id = $urandom_range(0, 1) ? ID_ALL_ONES : ID_NONE;
    end else begin
      r.id = $urandom;
    end
    r.slot = SLOT_W'($urandom_range(0, 2 ** SLOT_W - 1));
    if (pick < 35) begin
      r.cmd = CMD_ADD;
    end else if (pick < 55) begin
      r.cmd = CMD_CHECK;
    end else if (pick < 67) begin
      r.cmd = CMD_REMOVE;
    end else if (pick < 91) begin
      r.cmd = CMD_READ;
    end else if (pick < 93) begin
      r.cmd = CMD_CLEAR;
    end else begin
      r.cmd = CMD_W'($urandom_range(int'(CMD_READ) + 1, 2 ** CMD_W - 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Request driver: offers queued requests, with random gaps until the calm tail.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_verdicts.push_back(apply_to_allow_list(on_bus));
        requests_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          on_bus = queued_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(S_TDATA_W - ID_W - SLOT_W){1'b0}}, on_bus.slot, on_bus.id};
          s_axis_tuser  <= on_bus.cmd;
          if (!tail_calm && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      tail_calm <= (queued_requests.size() < CALM_TAIL);
    end
  end

  // Result monitor and receiver: checks each verdict and paces tready, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata=%h", m_axis_tdata));
        end else begin
          verdict_t want;
          want = pending_verdicts.pop_front();
          if (m_axis_tdata[M_OK_LSB] !== want.ok)
            report_mismatch($sformatf("result %0d ok: got %b want %b", results_seen,
                                      m_axis_tdata[M_OK_LSB], want.ok));
          if (m_axis_tdata[M_VALUE_LSB +: ID_W] !== want.value)
            report_mismatch($sformatf("result %0d slot_value: got %h want %h", results_seen,
                                      m_axis_tdata[M_VALUE_LSB +: ID_W], want.value));
          if (m_axis_tdata[M_COUNT_LSB +: COUNT_OUT_W] !== want.count)
            report_mismatch($sformatf("result %0d entry_count: got %0d want %0d", results_seen,
                                      m_axis_tdata[M_COUNT_LSB +: COUNT_OUT_W], want.count));
          if (m_axis_tdata[M_CHANGED_LSB] !== want.changed)
            report_mismatch($sformatf("result %0d table_changed: got %b want %b",
                                      results_seen, m_axis_tdata[M_CHANGED_LSB],
                                      want.changed));
        end
        results_seen++;
        if (results_seen == LONG_HOLD_AT) begin
          hold_left = LONG_HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!tail_calm && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 16);
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a request or result for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed requests first, then random ones, then wait for every verdict.
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_ids[i] = '0;
    end
    shadow_count = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      known_ids[i] = $urandom;
    end

    // Empty table: open mode and an empty read.
    queued_requests.push_back(make_request(CMD_CHECK, 32'hDEAD_BEEF, 3'd0));
    queued_requests.push_back(make_request(CMD_READ, 32'h0, 3'd7));
    // Reserved IDs are refused.
    queued_requests.push_back(make_request(CMD_ADD, ID_NONE, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, ID_ALL_ONES, 3'd0));
    // Fill the table to the brim, then overflow it and add a duplicate.
    queued_requests.push_back(make_request(CMD_ADD, 32'h0000_0001, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'hFFFF_FFFE, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h8000_0000, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h7FFF_FFFF, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h1234_5678, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'hA5A5_A5A5, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h5A5A_5A5A, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h0000_0002, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'hCAFE_F00D, 3'd0));
    queued_requests.push_back(make_request(CMD_ADD, 32'h8000_0000, 3'd0));
    queued_requests.push_back(make_request(CMD_CHECK, 32'h1234_5678, 3'd0));
    queued_requests.push_back(make_request(CMD_CHECK, 32'hCAFE_F00D, 3'd0));
    // Remove from the middle, then look at the shifted and freed slots.
    queued_requests.push_back(make_request(CMD_REMOVE, 32'h8000_0000, 3'd0));
    queued_requests.push_back(make_request(CMD_READ, 32'hFFFF_FFFF, 3'd2));
    queued_requests.push_back(make_request(CMD_READ, 32'h0, 3'd7));
    queued_requests.push_back(make_request(CMD_REMOVE, 32'hCAFE_F00D, 3'd0));
    queued_requests.push_back(make_request(CMD_REMOVE, 32'h0000_0002, 3'd0));
    // Clear a populated table and an empty one.
    queued_requests.push_back(make_request(CMD_CLEAR, 32'h0, 3'd0));
    queued_requests.push_back(make_request(CMD_CLEAR, 32'h0, 3'd0));
    // Unused command codes.
    for (int c = int'(CMD_READ) + 1; c < 2 ** CMD_W; c++) begin
      queued_requests.push_back(make_request(CMD_W'(c), 32'h0000_0001, 3'd5));
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      queued_requests.push_back(random_request());
    end
    requests_total = queued_requests.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent != requests_total || pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== paired_id_allow_table_top.f =====
rtl/apit_pkg.sv
rtl/paired_id_allow_table_top.sv
rtl/apit_checker.sv
tb/sv/tb_top.sv
